[sv/soa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_pkg
// shared types and constants of the slot offset allocator
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int unsigned MaxSlots  = 1024;
  localparam int unsigned AddrW     = $clog2(MaxSlots);
  localparam int unsigned DepthW    = AddrW + 1;
  localparam int unsigned OffsetW   = 32;
  localparam int unsigned SizeW     = 17;
  localparam int unsigned CountW    = 11;
  localparam int unsigned LimitW    = SizeW + CountW;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [SizeW-1:0]  SizeReset  = SizeW'(64);
  localparam logic [CountW-1:0] CountReset = CountW'(1024);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOCAP = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLOT_SIZE  = 1'b0,
    CFG_SLOT_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_UPDATE = 2'd2
  } state_e;

endpackage

[sv/soa_stack_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_stack_ram
// free stack storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module soa_stack_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [soa_pkg::AddrW-1:0]     waddr_i,
  input  logic [soa_pkg::OffsetW-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [soa_pkg::AddrW-1:0]     raddr_i,
  output logic [soa_pkg::OffsetW-1:0]   rdata_o
);

  logic [soa_pkg::OffsetW-1:0] mem_q [soa_pkg::MaxSlots];
  logic [soa_pkg::OffsetW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/slot_offset_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_offset_allocator
// hands out fixed-size slot offsets from a lifo free stack or a bump pointer
// ----------------------------------------------------------------------------
// usage:
//   request channel: start_i with op_i and slot_offset_in_i is taken at a
//   rising edge where busy_o is low. op alloc pops the last freed offset, or
//   when the stack is empty returns the bump pointer and advances it by
//   slot_size; op free pushes slot_offset_in_i onto the stack.
//   result channel: done_o is high for exactly one cycle with
//   slot_offset_out_o and status_o (ok, out of capacity, stack full). the
//   receiver cannot stall, so results are never held back.
//   config port: cfg_we_i writes cfg_wdata_i into slot_size (index 0) or
//   slot_count (index 1); write only while no request is in flight.
//   sequence: an accepted request passes S_READ, then S_UPDATE; done_o is
//   registered from S_UPDATE. S_READ reads the top of the free stack memory
//   (synchronous read), S_UPDATE updates the stack pointer, bump pointer and
//   memory. a new request may be taken during the update cycle, so reads
//   always see the committed stack depth.
//   reset: stack depth and bump pointer clear, slot_size goes to 64 and
//   slot_count to 1024. the stack memory itself is not cleared; only entries
//   that a free wrote are ever popped.
// ----------------------------------------------------------------------------
module slot_offset_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             op_i,
  input  logic [soa_pkg::OffsetW-1:0]      slot_offset_in_i,
  // result channel
  output logic                             done_o,
  output logic [soa_pkg::OffsetW-1:0]      slot_offset_out_o,
  output logic [1:0]                       status_o,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [soa_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [soa_pkg::SizeW-1:0]        cfg_wdata_i
);

  // configuration registers
  logic [soa_pkg::SizeW-1:0]   slot_size_q;
  logic [soa_pkg::CountW-1:0]  slot_count_q;
  // buffer size in bytes, refreshed every cycle from the config registers
  logic [soa_pkg::LimitW-1:0]  limit_q;

  // control state
  soa_pkg::state_e             state_q, state_d;
  logic [soa_pkg::DepthW-1:0]  depth_q, depth_d;
  logic [soa_pkg::LimitW-1:0]  bump_q, bump_d;

  // captured request
  soa_pkg::op_e                op_q;
  logic [soa_pkg::OffsetW-1:0] off_in_q;

  // result registers
  logic                        done_q, done_d;
  logic [soa_pkg::OffsetW-1:0] res_off_q, res_off_d;
  soa_pkg::status_e            res_st_q, res_st_d;

  // memory handshake
  logic                        ram_we;
  logic                        ram_re;
  logic [soa_pkg::AddrW-1:0]   ram_raddr;
  logic [soa_pkg::OffsetW-1:0] ram_rdata;

  logic                        accept;
  logic                        stack_empty;
  logic                        stack_full;
  logic [soa_pkg::LimitW:0]    bump_sum;
  logic                        no_cap;

  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_size_q  <= soa_pkg::SizeReset;
      slot_count_q <= soa_pkg::CountReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        soa_pkg::CFG_SLOT_SIZE:  slot_size_q  <= cfg_wdata_i;
        soa_pkg::CFG_SLOT_COUNT: slot_count_q <= cfg_wdata_i[soa_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // 17x11 product, settled in the read cycle before the compare uses it
  always_ff @(posedge clk_i) begin
    limit_q <= soa_pkg::LimitW'(slot_size_q) * soa_pkg::LimitW'(slot_count_q);
  end

  // ---------------------------------------------------------------------------
  // free stack memory: read top in S_READ, push in S_UPDATE
  // ---------------------------------------------------------------------------
  assign ram_re    = (state_q == soa_pkg::S_READ);
  assign ram_raddr = soa_pkg::AddrW'(depth_q - soa_pkg::DepthW'(1));

  soa_stack_ram u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (depth_q[soa_pkg::AddrW-1:0]),
    .wdata_i (off_in_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // update logic
  // ---------------------------------------------------------------------------
  assign stack_empty = (depth_q == '0);
  assign stack_full  = (depth_q == soa_pkg::DepthW'(soa_pkg::MaxSlots));
  assign bump_sum    = {1'b0, bump_q} + (soa_pkg::LimitW + 1)'(slot_size_q);
  assign no_cap      = bump_sum > {1'b0, limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= soa_pkg::S_IDLE;
      depth_q <= '0;
      bump_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      bump_q  <= bump_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= soa_pkg::op_e'(op_i);
      off_in_q <= slot_offset_in_i;
    end
    res_off_q <= res_off_d;
    res_st_q  <= res_st_d;
  end

  always_comb begin
    state_d   = state_q;
    depth_d   = depth_q;
    bump_d    = bump_q;
    done_d    = 1'b0;
    res_off_d = '0;
    res_st_d  = soa_pkg::ST_OK;
    ram_we    = 1'b0;
    busy_o    = 1'b0;

    case (state_q)
      soa_pkg::S_IDLE: begin
        if (accept) begin
          state_d = soa_pkg::S_READ;
        end
      end
      soa_pkg::S_READ: begin
        busy_o  = 1'b1;
        state_d = soa_pkg::S_UPDATE;
      end
      soa_pkg::S_UPDATE: begin
        // result goes out next cycle; a new request may enter right now
        done_d  = 1'b1;
        state_d = accept ? soa_pkg::S_READ : soa_pkg::S_IDLE;
        if (op_q == soa_pkg::OP_ALLOC) begin
          if (!stack_empty) begin
            depth_d   = depth_q - soa_pkg::DepthW'(1);
            res_off_d = ram_rdata;
          end else if (no_cap) begin
            res_st_d = soa_pkg::ST_NOCAP;
          end else begin
            res_off_d = soa_pkg::OffsetW'(bump_q);
            // sum never exceeds the limit here, so it fits
            bump_d    = bump_sum[soa_pkg::LimitW-1:0];
          end
        end else begin
          if (stack_full) begin
            res_st_d = soa_pkg::ST_FULL;
          end else begin
            ram_we  = 1'b1;
            depth_d = depth_q + soa_pkg::DepthW'(1);
          end
        end
      end
      default: begin
        state_d = soa_pkg::S_IDLE;
      end
    endcase
  end

  assign done_o            = done_q;
  assign slot_offset_out_o = res_off_q;
  assign status_o          = res_st_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // every accepted request is followed by its result strobe
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##2 done_o)
    else $error("request accepted without its result strobe");

  // stack depth never passes the memory size
  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= soa_pkg::DepthW'(soa_pkg::MaxSlots))
    else $error("free stack depth out of range");

  // an error result carries a zero offset
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != soa_pkg::ST_OK) |-> slot_offset_out_o == '0)
    else $error("error result with nonzero offset");

  // the bump pointer only moves on a successful allocation from it
  a_bump_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bump_q != $past(bump_q)) |-> $past(state_q == soa_pkg::S_UPDATE)
      && $past(op_q == soa_pkg::OP_ALLOC) && $past(stack_empty))
    else $error("bump pointer moved outside a bump allocation");

endmodule

[tb/slot_offset_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_offset_allocator_tb
// self-checking bench for the slot offset allocator
// ----------------------------------------------------------------------------
// drives alloc and free items through the start/busy port and keeps its own
// model of the lifo free stack, the bump pointer and both registers. every
// accepted item queues the offset and status it must produce, and each done
// strobe is checked against the oldest entry. a directed pass covers the
// register extremes, zero slot size, zero slot count and the edge offsets.
// random phases then mix alloc bursts with frees of held offsets, and sender
// gaps vary from phase to phase.
// ----------------------------------------------------------------------------
module slot_offset_allocator_tb;

  localparam int unsigned ReportMax = 10;

  typedef struct {
    logic [soa_pkg::OffsetW-1:0] offset;
    soa_pkg::status_e            status;
    bit                          from_alloc;
  } alloc_result_t;

  // ---------------------------------------------------------------------------
  // scoreboard: predicts each result when its item is accepted
  // ---------------------------------------------------------------------------
  class alloc_scoreboard;
    logic [soa_pkg::OffsetW-1:0] freed_mem [soa_pkg::MaxSlots];
    int unsigned                 stack_depth;
    logic [soa_pkg::OffsetW-1:0] bump_ptr;
    logic [soa_pkg::SizeW-1:0]   slot_size;
    logic [soa_pkg::CountW-1:0]  slot_count;
    alloc_result_t               expected_q [$];
    logic [soa_pkg::OffsetW-1:0] held_q [$];  // offsets handed out and not yet freed
    int unsigned                 mismatches;

    function new();
      stack_depth = 0;
      bump_ptr    = '0;
      slot_size   = soa_pkg::SizeReset;
      slot_count  = soa_pkg::CountReset;
      mismatches  = 0;
    endfunction

    function void write_reg(soa_pkg::cfg_idx_e idx, logic [soa_pkg::SizeW-1:0] value);
      if (idx == soa_pkg::CFG_SLOT_SIZE) begin
        slot_size = value;
      end else begin
        slot_count = value[soa_pkg::CountW-1:0];
      end
    endfunction

    function void note_request(soa_pkg::op_e op, logic [soa_pkg::OffsetW-1:0] offset_in);
      alloc_result_t    exp_res;
      longint unsigned  limit;
      exp_res.offset     = '0;
      exp_res.status     = soa_pkg::ST_OK;
      exp_res.from_alloc = (op == soa_pkg::OP_ALLOC);
      if (op == soa_pkg::OP_ALLOC) begin
        if (stack_depth > 0) begin
          // lifo: the last freed offset comes back first
          stack_depth--;
          exp_res.offset = freed_mem[stack_depth];
        end else begin
          limit = longint'(slot_size) * longint'(slot_count);
          if (longint'(bump_ptr) + longint'(slot_size) > limit) begin
            exp_res.status = soa_pkg::ST_NOCAP;
          end else begin
            exp_res.offset = bump_ptr;
            bump_ptr       = bump_ptr + soa_pkg::OffsetW'(slot_size);
          end
        end
      end else begin
        if (stack_depth >= soa_pkg::MaxSlots) begin
          exp_res.status = soa_pkg::ST_FULL;  // dropped, nothing changes
        end else begin
          freed_mem[stack_depth] = offset_in;
          stack_depth++;
        end
      end
      expected_q = {expected_q, exp_res};
    endfunction

    function void check_result(logic [soa_pkg::OffsetW-1:0] offset_out,
                               logic [1:0] status_out);
      alloc_result_t exp_res;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax) begin
          $display("%0t: unexpected result offset=%h status=%0d", $realtime, offset_out,
                   status_out);
        end
        return;
      end
      exp_res = expected_q.pop_front();
      if (offset_out !== exp_res.offset || status_out !== exp_res.status) begin
        mismatches++;
        if (mismatches <= ReportMax) begin
          $display("%0t: result offset=%h status=%0d, expected offset=%h status=%0d",
                   $realtime, offset_out, status_out, exp_res.offset, exp_res.status);
        end
      end else if (exp_res.from_alloc && exp_res.status == soa_pkg::ST_OK) begin
        held_q = {held_q, exp_res.offset};
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and dut
  // ---------------------------------------------------------------------------
  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         start_i          = 1'b0;
  logic                         busy_o;
  soa_pkg::op_e                 op_i             = soa_pkg::OP_ALLOC;
  logic [soa_pkg::OffsetW-1:0]  slot_offset_in_i = '0;
  logic                         done_o;
  logic [soa_pkg::OffsetW-1:0]  slot_offset_out_o;
  logic [1:0]                   status_o;
  logic                         cfg_we_i         = 1'b0;
  soa_pkg::cfg_idx_e            cfg_index_i      = soa_pkg::CFG_SLOT_SIZE;
  logic [soa_pkg::SizeW-1:0]    cfg_wdata_i      = '0;

  alloc_scoreboard sb = new();

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  slot_offset_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .slot_offset_in_i (slot_offset_in_i),
    .done_o           (done_o),
    .slot_offset_out_o(slot_offset_out_o),
    .status_o         (status_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // accepted items go to the model before results are checked, so an item
  // taken on the same edge as an older result just queues behind it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        sb.note_request(op_i, slot_offset_in_i);
      end
      if (done_o) begin
        sb.check_result(slot_offset_out_o, status_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers, all called right after a rising edge
  // ---------------------------------------------------------------------------

  // start stays high from one item to the next unless a gap is inserted
  task automatic send_item(soa_pkg::op_e op, logic [soa_pkg::OffsetW-1:0] offset);
    start_i          <= 1'b1;
    op_i             <= op;
    slot_offset_in_i <= offset;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_cycles(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // wait until every result is back, then let the pipeline settle
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // only called after drain, so no item is in flight
  task automatic write_reg(soa_pkg::cfg_idx_e idx, logic [soa_pkg::SizeW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic set_geometry(logic [soa_pkg::SizeW-1:0] size,
                              logic [soa_pkg::CountW-1:0] count);
    drain();
    write_reg(soa_pkg::CFG_SLOT_SIZE, size);
    write_reg(soa_pkg::CFG_SLOT_COUNT, soa_pkg::SizeW'(count));
    @(posedge clk_i);
  endtask

  // the bump pointer never moves back, so pick a geometry that leaves a few
  // slots of headroom above it and capacity runs out soon after
  task automatic random_geometry();
    longint unsigned size;
    longint unsigned count;
    size = ($urandom_range(0, 9) == 0) ? $urandom_range(257, 4096) : $urandom_range(1, 256);
    count = sb.bump_ptr / size + $urandom_range(0, 8);
    while (count > 2047) begin
      size  = (size * 2 > 131071) ? 131071 : size * 2;
      count = sb.bump_ptr / size + $urandom_range(0, 8);
    end
    set_geometry(soa_pkg::SizeW'(size), soa_pkg::CountW'(count));
  endtask

  // mostly alloc bursts and frees of held offsets; some frees are noise
  task automatic random_items(int unsigned n, int unsigned gap_pct);
    int unsigned                 pick;
    logic [soa_pkg::OffsetW-1:0] offset;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < gap_pct) begin
        idle_cycles($urandom_range(1, 4));
      end
      if ($urandom_range(0, 99) < 55) begin
        send_item(soa_pkg::OP_ALLOC, $urandom());
      end else begin
        if (sb.held_q.size() != 0 && $urandom_range(0, 99) < 80) begin
          pick   = $urandom_range(0, sb.held_q.size() - 1);
          offset = sb.held_q[pick];
          sb.held_q.delete(pick);
        end else begin
          offset = $urandom();
        end
        send_item(soa_pkg::OP_FREE, offset);
      end
    end
  endtask

  task automatic random_phase(int unsigned n, int unsigned gap_pct);
    for (int unsigned part = 0; part < 4; part++) begin
      random_geometry();
      random_items(n / 4, gap_pct);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset geometry: two bump allocs, then lifo order of two frees
    send_item(soa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
    send_item(soa_pkg::OP_ALLOC, 32'h0000_0000);
    send_item(soa_pkg::OP_FREE, 32'hFFFF_FFFF);
    send_item(soa_pkg::OP_FREE, 32'h0000_0000);
    send_item(soa_pkg::OP_ALLOC, 32'h0);
    send_item(soa_pkg::OP_ALLOC, 32'h0);
    send_item(soa_pkg::OP_ALLOC, 32'h0);

    // zero slot size makes the limit zero, so bump allocs report out of capacity
    set_geometry('0, soa_pkg::CountW'(2));
    send_item(soa_pkg::OP_ALLOC, 32'h0);
    send_item(soa_pkg::OP_ALLOC, 32'h0);

    // zero slot count leaves an empty bump region, only pops succeed
    set_geometry(soa_pkg::SizeW'(5), '0);
    send_item(soa_pkg::OP_ALLOC, 32'h0);
    send_item(soa_pkg::OP_FREE, 32'hA5A5_5A5A);
    send_item(soa_pkg::OP_ALLOC, 32'h0);
    send_item(soa_pkg::OP_ALLOC, 32'h0);

    // widest registers, then a single tiny slot that is already used up
    set_geometry(soa_pkg::SizeW'(131071), soa_pkg::CountW'(2047));
    send_item(soa_pkg::OP_ALLOC, 32'h0);
    send_item(soa_pkg::OP_ALLOC, 32'h0);
    set_geometry(soa_pkg::SizeW'(1), soa_pkg::CountW'(1));
    send_item(soa_pkg::OP_ALLOC, 32'h0);
    send_item(soa_pkg::OP_FREE, 32'h5A5A_A5A5);
    send_item(soa_pkg::OP_ALLOC, 32'h0);

    // sender gaps in about a quarter of the slots, then most, then none
    random_phase(276, 28);
    random_phase(276, 63);
    random_phase(276, 0);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
